// File: sv/knnv_pkg.sv
// Shared constants and types for the nearest-neighbor label vote block.
package knnv_pkg;

  localparam int unsigned DIMS_DEF      = 14;
  localparam int unsigned NEIGHBORS_DEF = 5;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned TOP_W     = 32;
  localparam int unsigned LABEL_W   = 8;
  localparam int unsigned LANE_W    = 16;
  localparam int unsigned LANES_USED = 14;
  localparam int unsigned VEC_W     = LANE_W * LANES_USED;
  localparam int unsigned BAND_W    = 3;
  localparam int unsigned COUNT_W   = 3;

  localparam int unsigned SQ_W   = 29;
  localparam int unsigned PART_W = SQ_W + 2;
  localparam int unsigned SUM_W  = PART_W + 2;
  localparam int unsigned DIST_W = 31;

  localparam logic [LANE_W-1:0]  PAD_MARK  = 16'h7FFF;
  localparam logic [DIST_W-1:0]  FAR_LIMIT = 31'h7FFF_FFFF;
  localparam logic [LABEL_W-1:0] POS_LABEL = 8'd1;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_QRY_LO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QRY_MID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QRY_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QRY_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_EN  = 3'd6;

  typedef struct packed {
    logic pad;
    logic pos;
    logic first;
    logic last;
  } flags_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } ld_t;

  typedef struct packed {
    logic [DIST_W-1:0] sq_sum;
    logic              keep;
    logic              pos;
    logic              first;
    logic              last;
  } dist_item_t;

  typedef struct packed {
    logic adv;
    logic clr;
    logic ins;
  } cell_ctl_t;

endpackage

// File: sv/knnv_if.sv
// Stream channels: candidate vector beats in, vote result beats out.
interface knnv_vec_if import knnv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  vec_dims_lo;
  logic [WORD_W-1:0]  vec_dims_mid;
  logic [WORD_W-1:0]  vec_dims_high;
  logic [TOP_W-1:0]   vec_dims_top;
  logic [LABEL_W-1:0] vec_label;
  logic               first_of_query;
  logic               last_of_query;

  modport source (
    output valid, vec_dims_lo, vec_dims_mid, vec_dims_high, vec_dims_top,
           vec_label, first_of_query, last_of_query,
    input  ready
  );
  modport sink (
    input  valid, vec_dims_lo, vec_dims_mid, vec_dims_high, vec_dims_top,
           vec_label, first_of_query, last_of_query,
    output ready
  );
endinterface

interface knnv_vote_if import knnv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] positive_count;
  logic               retry_wanted;

  modport source (output valid, positive_count, retry_wanted, input ready);
  modport sink (input valid, positive_count, retry_wanted, output ready);
endinterface

// File: sv/knnv_dist.sv
// Three-stage squared distance pipeline: lane squares, group sums, total and far test.
module knnv_dist import knnv_pkg::*; #(
  parameter int unsigned DIMS = DIMS_DEF
) (
  input  logic             clk_i,
  input  ld_t              ld_i,
  input  logic [VEC_W-1:0] qry_i,
  input  logic [VEC_W-1:0] cand_i,
  input  flags_t           flags_i,
  output dist_item_t       item_o
);

  localparam int unsigned GROUPS   = (DIMS + 3) / 4;
  localparam int unsigned SQ_SLOTS = GROUPS * 4;

  logic [SQ_W-1:0]   sq_c [SQ_SLOTS];
  logic [SQ_W-1:0]   sq_q [SQ_SLOTS];
  logic [PART_W-1:0] part_c [GROUPS];
  logic [PART_W-1:0] part_q [GROUPS];
  logic [SUM_W-1:0]  total;
  flags_t            fl1_q;
  flags_t            fl2_q;
  dist_item_t        s3_d;
  dist_item_t        s3_q;

  for (genvar d = 0; d < SQ_SLOTS; d++) begin : g_lane
    if (d < DIMS && d < LANES_USED) begin : g_live
      logic signed [LANE_W:0]   diff;
      logic signed [LANE_W-2:0] shr;
      logic signed [2*LANE_W-3:0] prod;
      always_comb begin
        diff = $signed({cand_i[d*LANE_W+LANE_W-1], cand_i[d*LANE_W +: LANE_W]})
             - $signed({qry_i[d*LANE_W+LANE_W-1], qry_i[d*LANE_W +: LANE_W]});
        shr  = diff[LANE_W:2];
        prod = shr * shr;
        sq_c[d] = prod[SQ_W-1:0];
      end
    end else begin : g_zero
      assign sq_c[d] = '0;
    end
  end

  for (genvar g = 0; g < GROUPS; g++) begin : g_group
    always_comb begin
      part_c[g] = '0;
      for (int j = 0; j < 4; j++) begin
        part_c[g] = part_c[g] + PART_W'(sq_q[g*4+j]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + SUM_W'(part_q[g]);
    end
    s3_d.sq_sum = total[DIST_W-1:0];
    s3_d.keep   = !fl2_q.pad && (total < SUM_W'(FAR_LIMIT));
    s3_d.pos    = fl2_q.pos;
    s3_d.first  = fl2_q.first;
    s3_d.last   = fl2_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      sq_q  <= sq_c;
      fl1_q <= flags_i;
    end
    if (ld_i.s2) begin
      part_q <= part_c;
      fl2_q  <= fl1_q;
    end
    if (ld_i.s3) begin
      s3_q <= s3_d;
    end
  end

  assign item_o = s3_q;

endmodule

// File: sv/knnv_cell.sv
// One neighbor slot of the sorted slot chain: worst at the head, shifts toward it on insert.
module knnv_cell import knnv_pkg::*; #(
  parameter int unsigned IDX_W = 3,
  parameter int unsigned SLOT  = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [DIST_W-1:0] new_dist_i,
  input  logic [IDX_W-1:0]  new_idx_i,
  input  logic              new_pos_i,
  input  logic [DIST_W-1:0] nb_dist_i,
  input  logic [IDX_W-1:0]  nb_idx_i,
  input  logic              nb_pos_i,
  input  logic              nb_ahead_i,
  output logic [DIST_W-1:0] cur_dist_o,
  output logic [IDX_W-1:0]  cur_idx_o,
  output logic              cur_pos_o,
  output logic              ahead_o,
  output logic              pos_next_o
);

  logic [DIST_W-1:0] dist_q, dist_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              pos_q, pos_d;

  assign cur_dist_o = ctl_i.clr ? FAR_LIMIT : dist_q;
  assign cur_idx_o  = ctl_i.clr ? IDX_W'(SLOT) : idx_q;
  assign cur_pos_o  = ctl_i.clr ? 1'b0 : pos_q;

  assign ahead_o = (cur_dist_o > new_dist_i)
                || ((cur_dist_o == new_dist_i) && (cur_idx_o < new_idx_i));

  always_comb begin
    dist_d = dist_q;
    idx_d  = idx_q;
    pos_d  = pos_q;
    if (ctl_i.adv) begin
      dist_d = cur_dist_o;
      idx_d  = cur_idx_o;
      pos_d  = cur_pos_o;
      if (ctl_i.ins) begin
        if (nb_ahead_i) begin
          dist_d = nb_dist_i;
          idx_d  = nb_idx_i;
          pos_d  = nb_pos_i;
        end else if (SLOT == 0 || ahead_o) begin
          dist_d = new_dist_i;
          idx_d  = new_idx_i;
          pos_d  = new_pos_i;
        end
      end
    end
  end

  assign pos_next_o = pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= FAR_LIMIT;
      idx_q  <= IDX_W'(SLOT);
      pos_q  <= 1'b0;
    end else begin
      dist_q <= dist_d;
      idx_q  <= idx_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// File: sv/knn_top5_label_vote_top.sv
// A last beat passes the square, sum and total stages; its vote is then registered.
// Throughput: one candidate beat and one slot chain entry per cycle while not stalled.
// The output register holds a waiting vote; later beats enter until a last beat stalls.
// Reset: query and band registers clear to zero, all slots empty (far distance, no label).
// No clearing pass; the block takes beats in the first cycle after reset.
module knn_top5_label_vote_top import knnv_pkg::*; #(
  parameter int unsigned DIMS      = DIMS_DEF,
  parameter int unsigned NEIGHBORS = NEIGHBORS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  knnv_vec_if.sink             vec_if,
  knnv_vote_if.source          vote_if
);

  localparam int unsigned IDX_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int unsigned CNT_W = $clog2(NEIGHBORS + 1);
  localparam int unsigned CMP_W = (CNT_W > BAND_W) ? CNT_W : BAND_W;

  logic [WORD_W-1:0]  qry_lo_q, qry_mid_q, qry_high_q;
  logic [TOP_W-1:0]   qry_top_q;
  logic [BAND_W-1:0]  band_low_q, band_high_q;
  logic               retry_en_q;

  logic               v1_q, v2_q, v3_q;
  logic               adv1, adv2, adv3, free1, free2, free3, acc;
  ld_t                ld;
  flags_t             flags;
  dist_item_t         s3;

  logic               out_valid_q;
  logic [COUNT_W-1:0] count_q;
  logic               retry_q;

  cell_ctl_t          ctl;
  logic [DIST_W-1:0]  cur_dist [NEIGHBORS];
  logic [IDX_W-1:0]   cur_idx  [NEIGHBORS];
  logic               cur_pos  [NEIGHBORS];
  logic               ahead    [NEIGHBORS];
  logic               pos_nxt  [NEIGHBORS];
  logic [CNT_W-1:0]   cnt;
  logic               retry_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qry_lo_q    <= '0;
      qry_mid_q   <= '0;
      qry_high_q  <= '0;
      qry_top_q   <= '0;
      band_low_q  <= '0;
      band_high_q <= '0;
      retry_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_QRY_LO:    qry_lo_q    <= cfg_wdata_i;
        CFG_QRY_MID:   qry_mid_q   <= cfg_wdata_i;
        CFG_QRY_HIGH:  qry_high_q  <= cfg_wdata_i;
        CFG_QRY_TOP:   qry_top_q   <= cfg_wdata_i[TOP_W-1:0];
        CFG_BAND_LOW:  band_low_q  <= cfg_wdata_i[BAND_W-1:0];
        CFG_BAND_HIGH: band_high_q <= cfg_wdata_i[BAND_W-1:0];
        CFG_RETRY_EN:  retry_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    adv3  = v3_q && !(s3.last && out_valid_q && !vote_if.ready);
    free3 = !v3_q || adv3;
    adv2  = v2_q && free3;
    free2 = !v2_q || adv2;
    adv1  = v1_q && free2;
    free1 = !v1_q || adv1;
    acc   = vec_if.valid && free1;
    ld.s1 = acc;
    ld.s2 = adv1;
    ld.s3 = adv2;
  end

  assign vec_if.ready = free1;

  always_comb begin
    flags.pad   = (vec_if.vec_dims_lo[LANE_W-1:0] == PAD_MARK);
    flags.pos   = (vec_if.vec_label == POS_LABEL);
    flags.first = vec_if.first_of_query;
    flags.last  = vec_if.last_of_query;
  end

  knnv_dist #(
    .DIMS (DIMS)
  ) u_dist (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .qry_i   ({qry_top_q, qry_high_q, qry_mid_q, qry_lo_q}),
    .cand_i  ({vec_if.vec_dims_top, vec_if.vec_dims_high,
               vec_if.vec_dims_mid, vec_if.vec_dims_lo}),
    .flags_i (flags),
    .item_o  (s3)
  );

  always_comb begin
    ctl.adv = adv3;
    ctl.clr = s3.first;
    ctl.ins = s3.keep && (s3.sq_sum < cur_dist[0]);
  end

  for (genvar k = 0; k < NEIGHBORS; k++) begin : g_slot
    if (k == NEIGHBORS - 1) begin : g_tail
      knnv_cell #(
        .IDX_W (IDX_W),
        .SLOT  (k)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .new_dist_i (s3.sq_sum),
        .new_idx_i  (cur_idx[0]),
        .new_pos_i  (s3.pos),
        .nb_dist_i  ('0),
        .nb_idx_i   ('0),
        .nb_pos_i   (1'b0),
        .nb_ahead_i (1'b0),
        .cur_dist_o (cur_dist[k]),
        .cur_idx_o  (cur_idx[k]),
        .cur_pos_o  (cur_pos[k]),
        .ahead_o    (ahead[k]),
        .pos_next_o (pos_nxt[k])
      );
    end else begin : g_body
      knnv_cell #(
        .IDX_W (IDX_W),
        .SLOT  (k)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .new_dist_i (s3.sq_sum),
        .new_idx_i  (cur_idx[0]),
        .new_pos_i  (s3.pos),
        .nb_dist_i  (cur_dist[k+1]),
        .nb_idx_i   (cur_idx[k+1]),
        .nb_pos_i   (cur_pos[k+1]),
        .nb_ahead_i (ahead[k+1]),
        .cur_dist_o (cur_dist[k]),
        .cur_idx_o  (cur_idx[k]),
        .cur_pos_o  (cur_pos[k]),
        .ahead_o    (ahead[k]),
        .pos_next_o (pos_nxt[k])
      );
    end
  end

  always_comb begin
    cnt = '0;
    for (int k = 0; k < NEIGHBORS; k++) begin
      cnt = cnt + CNT_W'(pos_nxt[k]);
    end
    retry_c = (CMP_W'(cnt) >= CMP_W'(band_low_q))
           && (CMP_W'(cnt) <= CMP_W'(band_high_q))
           && retry_en_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= acc || (v1_q && !adv1);
      v2_q        <= adv1 || (v2_q && !adv2);
      v3_q        <= adv2 || (v3_q && !adv3);
      out_valid_q <= (out_valid_q && !vote_if.ready) || (adv3 && s3.last);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && s3.last) begin
      count_q <= COUNT_W'(cnt);
      retry_q <= retry_c;
    end
  end

  assign vote_if.valid          = out_valid_q;
  assign vote_if.positive_count = count_q;
  assign vote_if.retry_wanted   = retry_q;

`ifndef NO_ASSERTIONS
  logic [NEIGHBORS-1:0] idx_mask;

  always_comb begin
    idx_mask = '0;
    for (int j = 0; j < NEIGHBORS; j++) begin
      for (int k = 0; k < NEIGHBORS; k++) begin
        if (cur_idx[k] == IDX_W'(j)) begin
          idx_mask[j] = 1'b1;
        end
      end
    end
  end

  a_slot_ids_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &idx_mask)
    else $error("slot ids not a permutation");

  for (genvar k = 0; k + 1 < NEIGHBORS; k++) begin : g_chk
    a_chain_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cur_dist[k] > cur_dist[k+1])
      || ((cur_dist[k] == cur_dist[k+1]) && (cur_idx[k] < cur_idx[k+1])))
      else $error("slot chain out of order");
  end

  a_vote_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv3 && s3.last))
    else $error("vote beat without a last-of-query item");
`endif

endmodule

// File: sim/testbench.sv
// Testbench for the nearest-neighbor label vote block: directed table, random queries, checks.
module testbench;
  import knnv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_CYCLES = 400;
  localparam int unsigned PHASES = 9;
  localparam int unsigned PHASE_BEATS = 150;
  localparam int unsigned DIR_N = 18;
  localparam int unsigned DIR_CFG_ROW = 11;

  localparam logic [WORD_W-1:0] WORD_MIN = {4{16'h8000}};
  localparam logic [WORD_W-1:0] WORD_MAX = {4{PAD_MARK}};
  localparam logic [TOP_W-1:0]  TOP_MIN  = {2{16'h8000}};
  localparam logic [TOP_W-1:0]  TOP_MAX  = {2{PAD_MARK}};
  localparam logic [WORD_W-1:0] PAD_ONLY = {48'h0, PAD_MARK};
  localparam logic [WORD_W-1:0] NEAR_LO  = {{3{PAD_MARK}}, 16'h7FFE};

  typedef struct packed {
    logic [WORD_W-1:0]  lo;
    logic [WORD_W-1:0]  mid;
    logic [WORD_W-1:0]  high;
    logic [TOP_W-1:0]   top;
    logic [LABEL_W-1:0] label;
    logic               first;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               retry;
  } vote_t;

  typedef struct packed {
    beat_t beat;
    logic  typed;
    vote_t vote;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0] cfg_wdata_i;

  knnv_vec_if vec_if ();
  knnv_vote_if vote_if ();

  knn_top5_label_vote_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .vec_if      (vec_if),
    .vote_if     (vote_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [WORD_W-1:0]  qry_lo, qry_mid, qry_high;
  logic [TOP_W-1:0]   qry_top;
  logic [BAND_W-1:0]  band_lo, band_hi;
  logic               retry_en;
  logic [31:0]        slot_dist [NEIGHBORS_DEF];
  logic [LABEL_W-1:0] slot_label [NEIGHBORS_DEF];
  int                 far_slot;

  vote_t pending_votes [$];
  int    err_cnt = 0;
  int    beats_sent = 0;
  int    votes_checked = 0;
  int    settings_used = 0;
  int    cycles = 0;
  bit    no_idle = 1'b0;
  bit    stall_req = 1'b0;

  row_t dir_rows [DIR_N] = '{
    '{'{PAD_ONLY, 64'h0, 64'h0, 32'h0, 8'd1, 1'b0, 1'b1}, 1'b1, '{3'd0, 1'b0}},
    '{'{64'h0, 64'h0, 64'h0, 32'h0, 8'd1, 1'b1, 1'b0}, 1'b0, '{3'd0, 1'b0}},
    '{'{64'h0, 64'h0, 64'h0, 32'h0, 8'd1, 1'b0, 1'b0}, 1'b0, '{3'd0, 1'b0}},
    '{'{64'h0, 64'h0, 64'h0, 32'h0, 8'd1, 1'b0, 1'b0}, 1'b0, '{3'd0, 1'b0}},
    '{'{64'h0, 64'h0, 64'h0, 32'h0, 8'd1, 1'b0, 1'b0}, 1'b0, '{3'd0, 1'b0}},
    '{'{64'h0, 64'h0, 64'h0, 32'h0, 8'd1, 1'b0, 1'b0}, 1'b0, '{3'd0, 1'b0}},
    '{'{64'h0, 64'h0, 64'h0, 32'h0, 8'd0, 1'b0, 1'b1}, 1'b1, '{3'd5, 1'b0}},
    '{'{WORD_MIN, WORD_MIN, WORD_MIN, TOP_MIN, 8'd1, 1'b1, 1'b1}, 1'b1, '{3'd1, 1'b0}},
    '{'{WORD_MAX, WORD_MAX, WORD_MAX, TOP_MAX, 8'd1, 1'b1, 1'b1}, 1'b1, '{3'd0, 1'b0}},
    '{'{64'h8000, 64'h0, 64'h0, 32'h0, 8'd255, 1'b1, 1'b0}, 1'b0, '{3'd0, 1'b0}},
    '{'{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'h5555_AAAA_3333_CCCC,
        32'h0F0F_F0F0, 8'd1, 1'b0, 1'b1}, 1'b0, '{3'd0, 1'b0}},
    '{'{WORD_MIN, WORD_MIN, WORD_MIN, TOP_MIN, 8'd1, 1'b1, 1'b1}, 1'b1, '{3'd0, 1'b0}},
    '{'{NEAR_LO, WORD_MAX, WORD_MAX, TOP_MAX, 8'd1, 1'b1, 1'b0}, 1'b0, '{3'd0, 1'b0}},
    '{'{NEAR_LO, WORD_MAX, WORD_MAX, TOP_MAX, 8'd1, 1'b0, 1'b0}, 1'b0, '{3'd0, 1'b0}},
    '{'{NEAR_LO, WORD_MAX, WORD_MAX, TOP_MAX, 8'd1, 1'b0, 1'b1}, 1'b1, '{3'd3, 1'b1}},
    '{'{PAD_ONLY, 64'h0, 64'h0, 32'h0, 8'd1, 1'b0, 1'b1}, 1'b0, '{3'd0, 1'b0}},
    '{'{64'h0, 64'h0, 64'h0, 32'h0, 8'd1, 1'b1, 1'b1}, 1'b0, '{3'd0, 1'b0}},
    '{'{{4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}}, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1},
      1'b0, '{3'd0, 1'b0}}
  };

  function automatic void clear_slots();
    int j;
    for (j = 0; j < NEIGHBORS_DEF; j++) begin
      slot_dist[j] = 32'(FAR_LIMIT);
      slot_label[j] = '0;
    end
    far_slot = 0;
  endfunction

  // Update the kept neighbors with one candidate and return the vote they give.
  function automatic vote_t apply_candidate(input beat_t b);
    logic [VEC_W-1:0] cv;
    logic [VEC_W-1:0] qv;
    longint unsigned total;
    int d, j, diff, step, pos;
    vote_t v;
    if (b.first) clear_slots();
    cv = {b.top, b.high, b.mid, b.lo};
    qv = {qry_top, qry_high, qry_mid, qry_lo};
    total = 0;
    for (d = 0; d < LANES_USED; d++) begin
      diff = int'($signed(cv[d*LANE_W +: LANE_W])) - int'($signed(qv[d*LANE_W +: LANE_W]));
      step = diff >>> 2;
      total += longint'(step) * longint'(step);
    end
    if (cv[LANE_W-1:0] != PAD_MARK && total < 64'(FAR_LIMIT)) begin
      if (total[31:0] < slot_dist[far_slot]) begin
        slot_dist[far_slot] = total[31:0];
        slot_label[far_slot] = b.label;
        far_slot = 0;
        for (j = 1; j < NEIGHBORS_DEF; j++) begin
          if (slot_dist[j] > slot_dist[far_slot]) far_slot = j;
        end
      end
    end
    pos = 0;
    for (j = 0; j < NEIGHBORS_DEF; j++) begin
      if (slot_label[j] == POS_LABEL) pos++;
    end
    v.count = COUNT_W'(pos);
    v.retry = (pos >= band_lo) && (pos <= band_hi) && retry_en;
    return v;
  endfunction

  function automatic beat_t make_candidate();
    beat_t b;
    logic [VEC_W-1:0] v;
    logic [VEC_W-1:0] q;
    int kind, d;
    q = {qry_top, qry_high, qry_mid, qry_lo};
    kind = $urandom_range(99);
    for (d = 0; d < LANES_USED; d++) begin
      if (kind < 55)
        v[d*LANE_W +: LANE_W] = q[d*LANE_W +: LANE_W] + 16'($urandom_range(16)) - 16'd8;
      else if (kind < 70)
        v[d*LANE_W +: LANE_W] = q[d*LANE_W +: LANE_W] + 16'($urandom_range(2048)) - 16'd1024;
      else if (kind < 90)
        v[d*LANE_W +: LANE_W] = 16'($urandom);
      else if (kind < 94)
        v[d*LANE_W +: LANE_W] = 16'h8000;
      else if (kind < 97)
        v[d*LANE_W +: LANE_W] = PAD_MARK;
      else
        v[d*LANE_W +: LANE_W] = q[d*LANE_W +: LANE_W] ^ 16'h8000;
    end
    if (kind >= 85 && kind < 90) v[LANE_W-1:0] = PAD_MARK;
    b.lo = v[0 +: WORD_W];
    b.mid = v[WORD_W +: WORD_W];
    b.high = v[2*WORD_W +: WORD_W];
    b.top = v[3*WORD_W +: TOP_W];
    b.label = ($urandom_range(3) == 0) ? LABEL_W'($urandom) : LABEL_W'($urandom_range(1));
    b.first = 1'b0;
    b.last = 1'b0;
    return b;
  endfunction

  task automatic send_beat(input beat_t b, input logic typed, input vote_t typed_vote);
    vote_t v;
    if (!no_idle && $urandom_range(99) < 9) begin
      vec_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    vec_if.valid <= 1'b1;
    vec_if.vec_dims_lo <= b.lo;
    vec_if.vec_dims_mid <= b.mid;
    vec_if.vec_dims_high <= b.high;
    vec_if.vec_dims_top <= b.top;
    vec_if.vec_label <= b.label;
    vec_if.first_of_query <= b.first;
    vec_if.last_of_query <= b.last;
    do @(posedge clk_i); while (!vec_if.ready);
    beats_sent++;
    v = apply_candidate(b);
    if (b.last) pending_votes.push_back(typed ? typed_vote : v);
  endtask

  // Hold the input idle until every vote is back and the pipeline has emptied.
  task automatic drain_votes();
    vec_if.valid <= 1'b0;
    while (pending_votes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_block(input logic [WORD_W-1:0] q_lo, input logic [WORD_W-1:0] q_mid,
                               input logic [WORD_W-1:0] q_high, input logic [WORD_W-1:0] q_top,
                               input logic [WORD_W-1:0] b_lo, input logic [WORD_W-1:0] b_hi,
                               input logic [WORD_W-1:0] r_en);
    logic [WORD_W-1:0] vals [7];
    logic [CFG_IDX_W-1:0] idx;
    int r;
    vals[CFG_QRY_LO] = q_lo;
    vals[CFG_QRY_MID] = q_mid;
    vals[CFG_QRY_HIGH] = q_high;
    vals[CFG_QRY_TOP] = q_top;
    vals[CFG_BAND_LOW] = b_lo;
    vals[CFG_BAND_HIGH] = b_hi;
    vals[CFG_RETRY_EN] = r_en;
    for (r = CFG_QRY_LO; r <= CFG_RETRY_EN; r++) begin
      idx = CFG_IDX_W'(r);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_wdata_i <= vals[r];
      @(posedge clk_i);
      case (idx)
        CFG_QRY_LO:    qry_lo = vals[r];
        CFG_QRY_MID:   qry_mid = vals[r];
        CFG_QRY_HIGH:  qry_high = vals[r];
        CFG_QRY_TOP:   qry_top = vals[r][TOP_W-1:0];
        CFG_BAND_LOW:  band_lo = vals[r][BAND_W-1:0];
        CFG_BAND_HIGH: band_hi = vals[r][BAND_W-1:0];
        CFG_RETRY_EN:  retry_en = vals[r][0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed queries with random content; some lack a first or last beat,
  // and some carry random flags.
  task automatic run_queries(input int n_beats);
    beat_t b;
    int sent, qlen, k, shape;
    sent = 0;
    while (sent < n_beats) begin
      qlen = $urandom_range(12, 1);
      shape = $urandom_range(9);
      for (k = 0; k < qlen; k++) begin
        b = make_candidate();
        b.first = (k == 0) && (shape != 0);
        b.last = (k == qlen - 1) && (shape != 1);
        if (shape == 9) begin
          b.first = 1'($urandom_range(1));
          b.last = 1'($urandom_range(1));
        end
        send_beat(b, 1'b0, '0);
      end
      sent += qlen;
    end
  endtask

  initial begin : vote_sink
    vote_t want;
    int stall_left;
    bit stall_done;
    stall_left = 0;
    stall_done = 1'b0;
    vote_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (vote_if.valid && vote_if.ready) begin
        if (pending_votes.size() == 0) begin
          err_cnt++;
          $display("%0t: vote with none expected: count %0d retry %0d", $time,
                   vote_if.positive_count, vote_if.retry_wanted);
        end else begin
          want = pending_votes.pop_front();
          votes_checked++;
          if (vote_if.positive_count !== want.count) begin
            err_cnt++;
            $display("%0t: positive_count expected %0d actual %0d", $time, want.count,
                     vote_if.positive_count);
          end
          if (vote_if.retry_wanted !== want.retry) begin
            err_cnt++;
            $display("%0t: retry_wanted expected %0d actual %0d", $time, want.retry,
                     vote_if.retry_wanted);
          end
        end
      end
      if (stall_req && !stall_done) begin
        stall_left = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        vote_if.ready <= 1'b0;
      end else begin
        vote_if.ready <= no_idle || ($urandom_range(99) >= 9);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d votes outstanding", $time, pending_votes.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int i, p;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_QRY_LO;
    cfg_wdata_i = '0;
    vec_if.valid = 1'b0;
    vec_if.vec_dims_lo = '0;
    vec_if.vec_dims_mid = '0;
    vec_if.vec_dims_high = '0;
    vec_if.vec_dims_top = '0;
    vec_if.vec_label = '0;
    vec_if.first_of_query = 1'b0;
    vec_if.last_of_query = 1'b0;
    qry_lo = '0;
    qry_mid = '0;
    qry_high = '0;
    qry_top = '0;
    band_lo = '0;
    band_hi = '0;
    retry_en = 1'b0;
    clear_slots();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_N; i++) begin
      if (i == DIR_CFG_ROW) begin
        drain_votes();
        program_block(WORD_MAX, WORD_MAX, WORD_MAX, 64'(TOP_MAX), 64'd2, 64'd4, 64'd1);
      end
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].vote);
    end

    for (p = 0; p < PHASES; p++) begin
      drain_votes();
      no_idle = (p == 3);
      stall_req = (p == 4);
      case (p)
        0: program_block(WORD_MIN, WORD_MIN, WORD_MIN, 64'(TOP_MIN), 64'd0, 64'd5, 64'd1);
        1: program_block(WORD_MAX, WORD_MAX, WORD_MAX, 64'(TOP_MAX), 64'd5, 64'd5, 64'd1);
        2: program_block({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, 64'd4, 64'd1, 64'd1);
        4: program_block(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd5, 64'd1);
        default: program_block({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom});
      endcase
      run_queries(PHASE_BEATS);
    end
    drain_votes();

    $display("covered %0d candidate beats over %0d register settings, %0d votes compared",
             beats_sent, settings_used, votes_checked);
    $display("mismatches: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
